// ===== design/dcuhf_pkg.sv =====
// Shared types, constants and sizes for the dual-channel unit-hydrograph FIR.
`default_nettype none
package dcuhf_pkg;

  localparam int TAPS = 32;

  // Address width of the per-channel stores, at least one bit.
  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  // Product step counter, runs 0 .. 2*TAPS.
  localparam int PW = $clog2(2 * TAPS + 1);
  // Fill count of the delay line, runs 0 .. TAPS.
  localparam int FW = $clog2(TAPS + 1);
  // Exact sum of 2*TAPS products of 32 bits.
  localparam int ACC_W = 32 + $clog2(2 * TAPS);

  localparam logic [23:0] FLOW_MAX = 24'hFF_FFFF;
  localparam logic [15:0] ROUND_HALF = 16'h8000;

  typedef enum logic [1:0] {
    FUNC_SAMPLE      = 2'd0,
    FUNC_LOAD_LAND   = 2'd1,
    FUNC_LOAD_GROUND = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] land_runoff;
    logic [15:0] ground_baseflow;
    logic [4:0]  tap_index;
    logic [15:0] tap_value;
  } in_t;

  typedef struct packed {
    logic [23:0] routed_flow;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic          hist_we;
    logic [AW-1:0] hist_waddr;
    logic          hist_re;
    logic [AW-1:0] hist_raddr;
    logic          kl_we;
    logic          kg_we;
    logic [AW-1:0] k_waddr;
    logic          k_re;
    logic [AW-1:0] k_raddr;
  } mem_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic sel_ground;
    logic hist_ok;
    logic kl_ok;
    logic kg_ok;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== design/dcuhf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dcuhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/dcuhf_mac.sv =====
// Shared 16x16 multiply-accumulate unit with rounding and saturation of the sum.
`default_nettype none
module dcuhf_mac (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dcuhf_pkg::mac_ctrl_t  ctrl_i,
  input  wire logic [31:0]           hist_rdata_i,
  input  wire logic [15:0]           kl_rdata_i,
  input  wire logic [15:0]           kg_rdata_i,
  output dcuhf_pkg::out_t            result_o
);
  import dcuhf_pkg::*;

  localparam int FLW = ACC_W + 1 - 16;

  logic [15:0]      op_a;
  logic [15:0]      op_b;
  logic             op_ok;
  logic [31:0]      prod_d, prod_q;
  logic             prod_v_d, prod_v_q;
  logic [ACC_W-1:0] acc_d, acc_q;
  logic [ACC_W:0]   rounded;
  logic [FLW-1:0]   flow;
  logic             sat;

  // Land sample is the upper half of the history word.
  always_comb begin
    op_a  = ctrl_i.sel_ground ? hist_rdata_i[15:0] : hist_rdata_i[31:16];
    op_b  = ctrl_i.sel_ground ? kg_rdata_i : kl_rdata_i;
    op_ok = ctrl_i.hist_ok && (ctrl_i.sel_ground ? ctrl_i.kg_ok : ctrl_i.kl_ok);
    prod_d   = op_ok ? (32'(op_a) * 32'(op_b)) : 32'd0;
    prod_v_d = ctrl_i.mul_en;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= prod_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // Round half up to Q16.8, then clip.
  always_comb begin
    rounded = {1'b0, acc_q} + (ACC_W + 1)'(ROUND_HALF);
    flow    = rounded[ACC_W:16];
    sat     = 32'(flow) > 32'(FLOW_MAX);
    result_o.routed_flow = sat ? FLOW_MAX : 24'(flow);
    result_o.saturated   = sat;
  end

endmodule
`default_nettype wire

// ===== design/dcuhf_seq.sv =====
// Sequencer: item intake, delay-line pointers, tap valid bits and product stepping.
`default_nettype none
module dcuhf_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire dcuhf_pkg::in_t        in_data_i,
  output logic                       in_ready_o,
  input  wire logic                  out_free_i,
  output logic                       out_load_o,
  output dcuhf_pkg::mem_ctrl_t       mem_o,
  output dcuhf_pkg::mac_ctrl_t       mac_o
);
  import dcuhf_pkg::*;

  localparam logic [PW-1:0] P_LAST = PW'(2 * TAPS);
  localparam logic [AW-1:0] A_LAST = AW'(TAPS - 1);

  state_e        state_q, state_d;
  logic [PW-1:0] p_q, p_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [TAPS-1:0] klv_q, klv_d;
  logic [TAPS-1:0] kgv_q, kgv_d;
  logic          hist_ok_q, kl_ok_q, kg_ok_q;

  logic          accept;
  logic          take_sample;
  logic          idx_ok;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] tap_addr;
  logic [AW-1:0] k;
  logic          rd_en;

  assign accept      = in_valid_i && in_ready_o;
  assign take_sample = accept && (in_data_i.func == FUNC_SAMPLE);
  assign idx_ok      = 32'(in_data_i.tap_index) < TAPS;
  assign tap_addr    = AW'(in_data_i.tap_index);
  assign wp_next     = (wp_q == A_LAST) ? '0 : wp_q + 1'b1;
  assign k           = p_q[AW:1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_sample) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (p_q == P_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    rd_en      = (state_q == ST_RUN) && !p_q[0] && (p_q < P_LAST);
    out_load_o = (state_q == ST_DONE) && out_free_i;

    mem_o.hist_we    = take_sample;
    mem_o.hist_waddr = wp_next;
    mem_o.hist_re    = rd_en;
    mem_o.hist_raddr = rd_ptr_q;
    mem_o.kl_we      = accept && (in_data_i.func == FUNC_LOAD_LAND) && idx_ok;
    mem_o.kg_we      = accept && (in_data_i.func == FUNC_LOAD_GROUND) && idx_ok;
    mem_o.k_waddr    = tap_addr;
    mem_o.k_re       = rd_en;
    mem_o.k_raddr    = k;

    mac_o.clear      = take_sample;
    mac_o.mul_en     = (state_q == ST_RUN) && (p_q != '0);
    mac_o.sel_ground = !p_q[0];
    mac_o.hist_ok    = hist_ok_q;
    mac_o.kl_ok      = kl_ok_q;
    mac_o.kg_ok      = kg_ok_q;
  end

  // Pointers, fill count and tap valid bits
  always_comb begin
    p_d      = p_q;
    wp_d     = wp_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    klv_d    = klv_q;
    kgv_d    = kgv_q;
    if (take_sample) begin
      p_d      = '0;
      wp_d     = wp_next;
      rd_ptr_d = wp_next;
      if (32'(fill_q) < TAPS) fill_d = fill_q + 1'b1;
    end
    if (state_q == ST_RUN) p_d = p_q + 1'b1;
    // Walk from newest to oldest entry.
    if (rd_en) rd_ptr_d = (rd_ptr_q == '0) ? A_LAST : rd_ptr_q - 1'b1;
    if (mem_o.kl_we) klv_d[tap_addr] = 1'b1;
    if (mem_o.kg_we) kgv_d[tap_addr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      p_q      <= '0;
      wp_q     <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      klv_q    <= '0;
      kgv_q    <= '0;
    end else begin
      state_q  <= state_d;
      p_q      <= p_d;
      wp_q     <= wp_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      klv_q    <= klv_d;
      kgv_q    <= kgv_d;
    end
  end

  // Masks travel with the registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      hist_ok_q <= 32'(k) < 32'(fill_q);
      kl_ok_q   <= klv_q[k];
      kg_ok_q   <= kgv_q[k];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= TAPS)
    else $error("delay line fill count beyond depth");

  a_rd_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rd_ptr_q) < TAPS)
    else $error("history read pointer out of range");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> (state_q == ST_RUN) && (p_q == '0))
    else $error("sample beat did not start the product walk");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !take_sample) |=> in_ready_o)
    else $error("load beat did not return to idle");

  a_load_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> $past(state_q) == ST_DRAIN || $past(state_q) == ST_DONE)
    else $error("result loaded outside the finish step");

endmodule
`default_nettype wire

// ===== design/dual_channel_unit_hydrograph_fir.sv =====
// Top level of the dual-channel unit-hydrograph FIR router.
//
// Each sample beat (func 0) pushes one land runoff and one groundwater baseflow
// value into two delay lines and returns the rounded, saturated sum of both
// convolutions as Q16.8. No new beat is taken until the result of a sample is
// in the output register: one 16x16 multiplier walks the 2*TAPS products, land
// then ground for each tap, fed from registered-read memories that hold the
// history ring and the two kernels. Load beats (func 1 and 2) write one kernel
// tap and leave the unit ready for the next beat; loads at or beyond the tap
// count and func 3 are dropped. The result sits in an output register, so
// a new beat is taken while it waits. History reads as zero until written via
// a fill count and each tap via a valid bit, so no clearing pass follows reset.
`default_nettype none
module dual_channel_unit_hydrograph_fir (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dcuhf_pkg::in_t    in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dcuhf_pkg::out_t        out_data_o
);
  import dcuhf_pkg::*;

  mem_ctrl_t   mem;
  mac_ctrl_t   mac;
  logic        out_load;
  logic        out_free;
  logic [31:0] hist_rdata;
  logic [15:0] kl_rdata;
  logic [15:0] kg_rdata;
  out_t        result;
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  dcuhf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .mem_o      (mem),
    .mac_o      (mac)
  );

  dcuhf_ram #(.WIDTH(32), .DEPTH(TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem.hist_we),
    .waddr_i (mem.hist_waddr),
    .wdata_i ({in_data_i.land_runoff, in_data_i.ground_baseflow}),
    .re_i    (mem.hist_re),
    .raddr_i (mem.hist_raddr),
    .rdata_o (hist_rdata)
  );

  dcuhf_ram #(.WIDTH(16), .DEPTH(TAPS)) u_land_kernel_ram (
    .clk_i   (clk_i),
    .we_i    (mem.kl_we),
    .waddr_i (mem.k_waddr),
    .wdata_i (in_data_i.tap_value),
    .re_i    (mem.k_re),
    .raddr_i (mem.k_raddr),
    .rdata_o (kl_rdata)
  );

  dcuhf_ram #(.WIDTH(16), .DEPTH(TAPS)) u_ground_kernel_ram (
    .clk_i   (clk_i),
    .we_i    (mem.kg_we),
    .waddr_i (mem.k_waddr),
    .wdata_i (in_data_i.tap_value),
    .re_i    (mem.k_re),
    .raddr_i (mem.k_raddr),
    .rdata_o (kg_rdata)
  );

  dcuhf_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mac),
    .hist_rdata_i (hist_rdata),
    .kl_rdata_i   (kl_rdata),
    .kg_rdata_i   (kg_rdata),
    .result_o     (result)
  );

  // Output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
